// File: rtl/core/hue_ring_pixel_shader_defines.svh
// assertion macros for the hue ring pixel shader
`ifndef HUE_RING_PIXEL_SHADER_DEFINES_SVH
`define HUE_RING_PIXEL_SHADER_DEFINES_SVH

// checked on every edge outside reset
`define HRPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HRPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/hrps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrps_pkg
// shared types and constants of the hue ring pixel shader
// ----------------------------------------------------------------------------
package hrps_pkg;

  localparam int HUE_STEPS   = 360;
  localparam int CORDIC_STEPS = 16;
  localparam int ROOT_BITS    = 19;
  localparam int NUM_CELLS    = ROOT_BITS;

  typedef enum logic [1:0] {
    REG_IMAGE_SIDE   = 2'd0,
    REG_OUTER_RADIUS = 2'd1,
    REG_INNER_RADIUS = 2'd2
  } reg_index_t;

  typedef enum logic {
    CMD_SHADE = 1'b0,
    CMD_LOAD  = 1'b1
  } command_t;

  // word moving along the cell row
  typedef struct packed {
    logic               valid;
    logic               cmd;
    logic               spec;
    logic [16:0]        t_spec;
    logic signed [29:0] x;
    logic signed [29:0] y;
    logic signed [18:0] z;
    logic [38:0]        rem;
    logic [18:0]        root;
    logic [21:0]        d2;
    logic [8:0]         eidx;
    logic [23:0]        ecol;
  } hrps_cell_t;

  // atan(2^-i) in units of 1/65536 turn
  function automatic logic [13:0] turn_angle(input int i);
    logic [13:0] r;
    unique case (i)
      0: r = 14'd8192;
      1: r = 14'd4836;
      2: r = 14'd2555;
      3: r = 14'd1297;
      4: r = 14'd651;
      5: r = 14'd326;
      6: r = 14'd163;
      7: r = 14'd81;
      8: r = 14'd41;
      9: r = 14'd20;
      10: r = 14'd10;
      11: r = 14'd5;
      12: r = 14'd3;
      13: r = 14'd1;
      14: r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/hrps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrps_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hrps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 360
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/hrps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrps_cell
// one cell of the row: a cordic rotation (first 16 cells only) and one root bit
// ----------------------------------------------------------------------------
module hrps_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  hrps_pkg::hrps_cell_t d,
  output hrps_pkg::hrps_cell_t q
);
  import hrps_pkg::*;

  localparam int BIT = ROOT_BITS - 1 - STEP;

  hrps_cell_t         nxt;
  logic signed [29:0] xs;
  logic signed [29:0] ys;
  logic [38:0]        trial;

  always_comb begin
    nxt   = d;
    xs    = d.x >>> STEP;
    ys    = d.y >>> STEP;
    if (STEP < CORDIC_STEPS) begin
      if (d.y > 0) begin
        nxt.x = d.x + ys;
        nxt.y = d.y - xs;
        nxt.z = d.z + $signed({5'b0, turn_angle(STEP)});
      end else begin
        nxt.x = d.x - ys;
        nxt.y = d.y + xs;
        nxt.z = d.z - $signed({5'b0, turn_angle(STEP)});
      end
    end
    // restoring square root, bits found from the top down
    trial = ({20'b0, d.root} << (BIT + 1)) + (39'd1 << (2 * BIT));
    if (d.rem >= trial) begin
      nxt.rem       = d.rem - trial;
      nxt.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= nxt.valid;
    end
    if (en) begin
      q.cmd    <= nxt.cmd;
      q.spec   <= nxt.spec;
      q.t_spec <= nxt.t_spec;
      q.x      <= nxt.x;
      q.y      <= nxt.y;
      q.z      <= nxt.z;
      q.rem    <= nxt.rem;
      q.root   <= nxt.root;
      q.d2     <= nxt.d2;
      q.eidx   <= nxt.eidx;
      q.ecol   <= nxt.ecol;
    end
  end

endmodule

// File: rtl/core/hue_ring_pixel_shader.sv
`timescale 1ns / 1ps
// registers from input word to result word: input, row, index, table, output
// throughput one word per cycle: 19 cells of the angle and root row each
// take one root bit per cycle, the first 16 also one cordic rotation
// the whole row stalls only while the output register holds an untaken word
// synchronous active-high reset clears valid flags and restores the registers
// (side 256, outer radius 127, inner radius 108); the hue table is not cleared
// ----------------------------------------------------------------------------
// hue_ring_pixel_shader
// shades one pixel of a hue ring image per word, or loads a hue table entry
// ----------------------------------------------------------------------------
module hue_ring_pixel_shader #(
  parameter int MAX_SIDE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // pixel_x, pixel_y, entry_index, entry_color, zero pad
  input  logic        s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // red, green, blue, alpha
);
  import hrps_pkg::*;

  localparam logic [12:0] SIDE_LIMIT = 13'(MAX_SIDE);

  logic [10:0] image_side;
  logic [8:0]  outer_radius;
  logic [8:0]  inner_radius;
  logic [19:0] sq_o1, sq_o, sq_i, sq_im1;
  logic [8:0]  ri_m1;
  logic        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side   <= 11'd256;
      outer_radius <= 9'd127;
      inner_radius <= 9'd108;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_IMAGE_SIDE:
          image_side <= ({2'b0, cfg_data} > SIDE_LIMIT) ? SIDE_LIMIT[10:0] : cfg_data;
        REG_OUTER_RADIUS: outer_radius <= cfg_data[8:0];
        REG_INNER_RADIUS: inner_radius <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // squared radii, registered from the radius registers
  assign ri_m1 = inner_radius - 9'd1;
  always_ff @(posedge clk) begin
    sq_o1  <= ({10'b0, outer_radius} + 20'd1) * ({10'b0, outer_radius} + 20'd1);
    sq_o   <= {11'b0, outer_radius} * {11'b0, outer_radius};
    sq_i   <= {11'b0, inner_radius} * {11'b0, inner_radius};
    sq_im1 <= {11'b0, ri_m1} * {11'b0, ri_m1};
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage: offsets from the centre
  logic               a_valid, a_cmd;
  logic signed [11:0] a_dx, a_dy;
  logic [8:0]         a_eidx;
  logic [23:0]        a_ecol;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
    if (en) begin
      a_cmd  <= s_tuser;
      a_dx   <= $signed({2'b0, s_tdata[9:0]}) - $signed({2'b0, image_side[10:1]});
      a_dy   <= $signed({2'b0, s_tdata[19:10]}) - $signed({2'b0, image_side[10:1]});
      a_eidx <= s_tdata[28:20];
      a_ecol <= s_tdata[52:29];
    end
  end

  // distance and half-plane fold into the first word of the row
  hrps_cell_t         row [NUM_CELLS+1];
  hrps_cell_t         fold;
  logic signed [23:0] sqx, sqy;
  logic signed [29:0] ex, ey;

  always_comb begin
    sqx         = a_dx * a_dx;
    sqy         = a_dy * a_dy;
    ex          = 30'(a_dx) <<< 16;
    ey          = 30'(a_dy) <<< 16;
    fold.valid  = a_valid;
    fold.cmd    = a_cmd;
    fold.d2     = 22'(sqx + sqy);
    fold.rem    = {1'b0, fold.d2, 16'b0};
    fold.root   = '0;
    fold.eidx   = a_eidx;
    fold.ecol   = a_ecol;
    fold.spec   = (a_dy == 0) || (a_dx == 0);
    if (a_dy == 0) begin
      fold.t_spec = (a_dx < 0) ? 17'd65536 : 17'd32768;
    end else begin
      fold.t_spec = (a_dy > 0) ? 17'd49152 : 17'd16384;
    end
    if (a_dx < 0) begin
      fold.x = -ex;
      fold.y = -ey;
      fold.z = (a_dy > 0) ? 19'sd32768 : -19'sd32768;
    end else begin
      fold.x = ex;
      fold.y = ey;
      fold.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0].valid <= 1'b0;
    end else if (en) begin
      row[0].valid <= fold.valid;
    end
    if (en) begin
      row[0].cmd    <= fold.cmd;
      row[0].spec   <= fold.spec;
      row[0].t_spec <= fold.t_spec;
      row[0].x      <= fold.x;
      row[0].y      <= fold.y;
      row[0].z      <= fold.z;
      row[0].rem    <= fold.rem;
      row[0].root   <= fold.root;
      row[0].d2     <= fold.d2;
      row[0].eidx   <= fold.eidx;
      row[0].ecol   <= fold.ecol;
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    hrps_cell #(.STEP(k)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (row[k]),
      .q   (row[k+1])
    );
  end

  // hue index and coverage
  hrps_cell_t         tail;
  logic signed [19:0] tz;
  logic [16:0]        t;
  logic [25:0]        tscaled;
  logic signed [21:0] cov;
  logic [8:0]         coef;
  logic               in_band, solid;

  always_comb begin
    tail = row[NUM_CELLS];
    tz   = 20'(tail.z) + 20'sd32768;
    if (tail.spec) begin
      t = tail.t_spec;
    end else if (tz < 0) begin
      t = '0;
    end else if (tz > 20'sd65536) begin
      t = 17'd65536;
    end else begin
      t = tz[16:0];
    end
    tscaled = {9'b0, t} * 26'(HUE_STEPS - 1);
    if ({2'b0, tail.d2} > sq_o) begin
      cov = $signed({4'b0, outer_radius + 9'd0, 8'b0} + 22'd256) - $signed({3'b0, tail.root});
    end else begin
      cov = 22'sd256 + $signed({3'b0, tail.root}) - $signed({5'b0, inner_radius, 8'b0});
    end
    in_band = ({2'b0, tail.d2} < sq_o1) && ((inner_radius == 0) || ({2'b0, tail.d2} > sq_im1));
    solid   = ({2'b0, tail.d2} < sq_o) && ({2'b0, tail.d2} > sq_i);
    priority if (!in_band) begin
      coef = '0;
    end else if (solid) begin
      coef = 9'd256;
    end else if (cov < 0) begin
      coef = '0;
    end else if (cov > 22'sd256) begin
      coef = 9'd256;
    end else begin
      coef = cov[8:0];
    end
  end

  logic        f_valid, f_cmd;
  logic [8:0]  f_idx, f_coef, f_eidx;
  logic [23:0] f_ecol;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= tail.valid;
    end
    if (en) begin
      f_cmd  <= tail.cmd;
      f_idx  <= tscaled[24:16];
      f_coef <= coef;
      f_eidx <= tail.eidx;
      f_ecol <= tail.ecol;
    end
  end

  // hue table; loads write in order with the shading reads
  logic [23:0] color;
  logic        g_valid;
  logic [8:0]  g_coef;

  hrps_ram #(.WIDTH(24), .DEPTH(HUE_STEPS)) u_table (
    .clk   (clk),
    .en    (en),
    .we    (en && f_valid && (f_cmd == CMD_LOAD) && ({23'b0, f_eidx} < 32'(HUE_STEPS))),
    .waddr (f_eidx),
    .wdata (f_ecol),
    .raddr (f_idx),
    .rdata (color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= f_valid && (f_cmd == CMD_SHADE);
    end
    if (en) begin
      g_coef <= f_coef;
    end
  end

  logic [16:0] pr, pg, pb, pa;

  assign pr = color[23:16] * g_coef;
  assign pg = color[15:8] * g_coef;
  assign pb = color[7:0] * g_coef;
  assign pa = 8'd255 * g_coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= g_valid;
    end
    if (en) begin
      m_tdata <= {pa[15:8], pb[15:8], pg[15:8], pr[15:8]};
    end
  end

endmodule

// File: rtl/core/hrps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrps_checker
// port-level checks of the hue ring pixel shader
// ----------------------------------------------------------------------------
`include "hue_ring_pixel_shader_defines.svh"

module hrps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // premultiplied colour never exceeds coverage
  `HRPS_ASSERT(a_premult, m_tvalid |-> (m_tdata[7:0] <= m_tdata[31:24]) && (m_tdata[15:8] <= m_tdata[31:24]) && (m_tdata[23:16] <= m_tdata[31:24]), "colour above alpha")
  // input side stalls exactly when a result word waits
  `HRPS_ASSERT(a_stall, s_tready == (!m_tvalid || m_tready), "input ready does not follow output")
  `HRPS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word dropped")
  `HRPS_ASSERT_ALWAYS(a_reset, rst |=> !m_tvalid, "result word after reset")

endmodule

bind hue_ring_pixel_shader hrps_checker u_hrps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hue ring pixel shader testbench
// fills the hue table, walks a short table of directed words, then random
// words under several register settings; every shaded pixel is checked
// against a typed value or a bench model of ring, cordic angle and coverage
// ----------------------------------------------------------------------------
module testbench;
  import hrps_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_IMAGE_SIDE;
  logic [10:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = CMD_SHADE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  hue_ring_pixel_shader uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow state of the block
  int unsigned side_reg = 256;
  int unsigned outer_reg = 127;
  int unsigned inner_reg = 108;
  logic [23:0] hue_shadow [HUE_STEPS];
  longint      turn_tab [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                 41, 20, 10, 5, 3, 1, 1, 0};

  logic [31:0] pixel_queue [$];
  int          errors = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  function automatic longint root_floor(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint angle_turn(longint dx, longint dy);
    longint x, y, z, xs, ys, t;
    if (dy == 0) return (dx < 0) ? 65536 : 32768;
    if (dx == 0) return (dy > 0) ? 49152 : 16384;
    if (dx < 0) begin
      x = -dx * 65536;
      y = -dy * 65536;
      z = (dy > 0) ? 32768 : -32768;
    end else begin
      x = dx * 65536;
      y = dy * 65536;
      z = 0;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += turn_tab[i];
      end else begin
        x -= ys; y += xs; z -= turn_tab[i];
      end
    end
    t = z + 32768;
    if (t < 0) t = 0;
    if (t > 65536) t = 65536;
    return t;
  endfunction

  // packed as m_tdata: red low byte, alpha top byte
  function automatic logic [31:0] shade_pixel(int x, int y);
    longint c, dx, dy, d2, ro, ri, idx, coef, s;
    logic [23:0] col;
    longint r, g, b;
    c = side_reg / 2;
    dx = x - c;
    dy = y - c;
    d2 = dx * dx + dy * dy;
    ro = outer_reg;
    ri = inner_reg;
    if (!(d2 < (ro + 1) * (ro + 1) && (ri == 0 || d2 > (ri - 1) * (ri - 1)))) return '0;
    idx = (angle_turn(dx, dy) * (HUE_STEPS - 1)) >> 16;
    if (idx < 0) idx = 0;
    if (idx >= HUE_STEPS) idx = HUE_STEPS - 1;
    col = hue_shadow[idx];
    r = col[23:16];
    g = col[15:8];
    b = col[7:0];
    if (d2 < ro * ro && d2 > ri * ri) return {8'd255, b[7:0], g[7:0], r[7:0]};
    s = root_floor(longint'(d2) << 16);
    if (d2 > ro * ro) coef = (ro + 1) * 256 - s;
    else coef = 256 + s - ri * 256;
    if (coef < 0) coef = 0;
    if (coef > 256) coef = 256;
    r = (r * coef) >> 8;
    g = (g * coef) >> 8;
    b = (b * coef) >> 8;
    s = (255 * coef) >> 8;
    return {s[7:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  // offers one word; typed_pixel is used when use_typed is set
  task automatic send_word(input command_t cmd, input int x, input int y,
                           input int eidx, input logic [23:0] ecol,
                           input bit use_typed, input logic [31:0] typed_pixel);
    while (!steady && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {3'b0, ecol, eidx[8:0], y[9:0], x[9:0]};
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_LOAD) begin
      if (eidx < HUE_STEPS) hue_shadow[eidx] = ecol;
    end else begin
      pixel_queue.push_back(use_typed ? typed_pixel : shade_pixel(x, y));
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    // trailing loads may still be in the row
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_SIDE: side_reg = (val > 1024) ? 1024 : val;
      REG_OUTER_RADIUS: outer_reg = val & 9'h1FF;
      default: inner_reg = val & 9'h1FF;
    endcase
  endtask

  task automatic random_words(input int count);
    int c, span, x, y;
    for (int n = 0; n < count; n++) begin
      c = side_reg / 2;
      span = outer_reg + 2;
      if ($urandom_range(99) < 12) begin
        send_word(CMD_LOAD, 0, 0, $urandom_range(511), 24'($urandom), 1'b0, '0);
      end else if ($urandom_range(99) < 12) begin
        send_word(CMD_SHADE, $urandom_range(1023), $urandom_range(1023), 0, 0, 1'b0, '0);
      end else begin
        x = c + $urandom_range(2 * span) - span;
        y = c + $urandom_range(2 * span) - span;
        x = (x < 0) ? 0 : (x > 1023) ? 1023 : x;
        y = (y < 0) ? 0 : (y > 1023) ? 1023 : y;
        send_word(CMD_SHADE, x, y, $urandom_range(511), 24'($urandom), 1'b0, '0);
      end
    end
  endtask

  typedef struct {
    command_t    cmd;
    int          x;
    int          y;
    int          eidx;
    logic [23:0] ecol;
    bit          typed;
    logic [31:0] pixel;
  } stim_row_t;

  // default registers: centre 128, outer 127, inner 108
  stim_row_t directed [] = '{
    '{CMD_LOAD,  0,    0,    0,   24'hFFFFFF, 0, 0},
    '{CMD_LOAD,  0,    0,    359, 24'h000000, 0, 0},
    '{CMD_LOAD,  0,    0,    360, 24'h123456, 0, 0},
    '{CMD_LOAD,  0,    0,    511, 24'hABCDEF, 0, 0},
    '{CMD_SHADE, 128,  128,  0,   0,          1, 32'h0},
    '{CMD_SHADE, 0,    0,    0,   0,          1, 32'h0},
    '{CMD_SHADE, 1023, 1023, 511, 24'hFFFFFF, 1, 32'h0},
    '{CMD_SHADE, 0,    1023, 0,   0,          1, 32'h0},
    '{CMD_SHADE, 245,  128,  0,   0,          0, 0},
    '{CMD_SHADE, 11,   128,  0,   0,          0, 0},
    '{CMD_SHADE, 128,  245,  0,   0,          0, 0},
    '{CMD_SHADE, 128,  11,   0,   0,          0, 0},
    '{CMD_SHADE, 255,  128,  0,   0,          0, 0},
    '{CMD_SHADE, 1,    128,  0,   0,          0, 0},
    '{CMD_SHADE, 236,  128,  0,   0,          0, 0},
    '{CMD_SHADE, 128,  20,   0,   0,          0, 0},
    '{CMD_SHADE, 210,  210,  0,   0,          0, 0},
    '{CMD_SHADE, 46,   46,   0,   0,          0, 0},
    '{CMD_SHADE, 128,  256,  0,   0,          0, 0},
    '{CMD_SHADE, 218,  218,  0,   0,          0, 0}
  };

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_queue.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        if (m_tdata !== pixel_queue[0]) begin
          $display("%0t: pixel mismatch, expected %h, actual %h (a b g r)",
                   $time, pixel_queue[0], m_tdata);
          errors++;
        end
        void'(pixel_queue.pop_front());
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 200;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 27);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < HUE_STEPS; i++)
      send_word(CMD_LOAD, 0, 0, i, 24'($urandom), 1'b0, '0);
    foreach (directed[i])
      send_word(directed[i].cmd, directed[i].x, directed[i].y, directed[i].eidx,
                directed[i].ecol, directed[i].typed, directed[i].pixel);
    random_words(70);
    // long receiver hold-off while words keep coming
    hold_req = 1'b1;
    random_words(70);
    drain();

    write_reg(REG_IMAGE_SIDE, 1024);
    write_reg(REG_OUTER_RADIUS, 511);
    write_reg(REG_INNER_RADIUS, 0);
    steady = 1'b1;
    random_words(100);
    steady = 1'b0;
    drain();

    write_reg(REG_IMAGE_SIDE, 1);
    write_reg(REG_OUTER_RADIUS, 0);
    random_words(40);
    drain();

    // side saturates, inner radius above outer
    write_reg(REG_IMAGE_SIDE, 2047);
    write_reg(REG_OUTER_RADIUS, 10);
    write_reg(REG_INNER_RADIUS, 20);
    random_words(50);
    drain();

    write_reg(REG_OUTER_RADIUS, 511);
    write_reg(REG_INNER_RADIUS, 511);
    random_words(50);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_IMAGE_SIDE, $urandom_range(1024, 1));
      write_reg(REG_OUTER_RADIUS, $urandom_range(300));
      write_reg(REG_INNER_RADIUS, $urandom_range(300));
      random_words(35);
      drain();
    end

    if (errors == 0) begin
      $display("hue_ring_pixel_shader test passed");
    end else begin
      $display("hue_ring_pixel_shader test failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("hue_ring_pixel_shader test failed");
    $finish;
  end

endmodule
